// File: design/twpi_pkg.sv
// ----------------------------------------------------------------------------
// twpi_pkg
// Types, codes and constants shared by the timed waypoint path interpolator.
// ----------------------------------------------------------------------------
package twpi_pkg;

   localparam int MAX_POINTS_DEFAULT = 64;
   localparam logic [31:0] MOVE_SPEED_RESET = 32'd65536;
   localparam logic [39:0] TIME_MAX = 40'hFF_FFFF_FFFF;

   localparam logic [1:0] CMD_BEGIN  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;
   localparam logic [1:0] CMD_STOP   = 2'd3;

   localparam logic [1:0] STATUS_MOVING  = 2'd0;
   localparam logic [1:0] STATUS_ARRIVED = 2'd1;
   localparam logic [1:0] STATUS_NO_PATH = 2'd2;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic [39:0]        time_ms;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [5:0]         segment;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [39:0] arrival;
   } way_type;

   typedef struct packed {
      logic        start;
      logic [39:0] r0;
      logic [42:0] dividend;
      logic [39:0] divisor;
      logic [5:0]  steps;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [42:0] quotient;
   } div_rsp_type;

   function automatic logic [31:0] axis_of(way_type w, logic [1:0] k);
      logic [31:0] v;
      case (k)
         AXIS_X:  v = w.x;
         AXIS_Y:  v = w.y;
         default: v = w.z;
      endcase
      return v;
   endfunction

endpackage

// File: design/twpi_way_mem.sv
// ----------------------------------------------------------------------------
// twpi_way_mem
// Waypoint store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module twpi_way_mem #(
   parameter int MAX_POINTS = twpi_pkg::MAX_POINTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_POINTS)-1:0] wr_addr,
   input  twpi_pkg::way_type             wr_data,
   input  logic [$clog2(MAX_POINTS)-1:0] rd_addr,
   output twpi_pkg::way_type             rd_data
);

   twpi_pkg::way_type mem [MAX_POINTS];
   twpi_pkg::way_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/twpi_sqrt.sv
// ----------------------------------------------------------------------------
// twpi_sqrt
// Restoring integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module twpi_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [65:0] radicand,
   output logic        done,
   output logic [32:0] root
);

   localparam logic [5:0] STEPS = 6'd33;

   logic [65:0] rad_ff;
   logic [35:0] rem_ff;
   logic [32:0] root_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [37:0] rem_in;
   logic [37:0] trial;
   logic        ge;

   assign rem_in = {rem_ff, rad_ff[65:64]};
   assign trial  = {3'd0, root_ff, 2'b01};
   assign ge     = rem_in >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= STEPS;
            rad_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (busy_ff) begin
            rad_ff  <= {rad_ff[63:0], 2'b00};
            rem_ff  <= ge ? 36'(rem_in - trial) : rem_in[35:0];
            root_ff <= {root_ff[31:0], ge};
            cnt_ff  <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// File: design/twpi_div.sv
// ----------------------------------------------------------------------------
// twpi_div
// Restoring divider, one quotient bit per cycle; shared by the travel time
// step and the segment fraction.
// ----------------------------------------------------------------------------
module twpi_div (
   input  logic                  clock,
   input  logic                  reset,
   input  twpi_pkg::div_req_type div_req,
   output twpi_pkg::div_rsp_type div_rsp
);

   logic [39:0] rem_ff;
   logic [42:0] dvd_ff;
   logic [42:0] quo_ff;
   logic [39:0] dsr_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [40:0] rem2;
   logic        ge;

   assign rem2 = {rem_ff, dvd_ff[42]};
   assign ge   = rem2 >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= div_req.steps;
            rem_ff  <= div_req.r0;
            dvd_ff  <= div_req.dividend;
            dsr_ff  <= div_req.divisor;
            quo_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= ge ? 40'(rem2 - {1'b0, dsr_ff}) : rem2[39:0];
            dvd_ff <= {dvd_ff[41:0], 1'b0};
            quo_ff <= {quo_ff[41:0], ge};
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// File: design/timed_waypoint_path_interpolator_top.sv
// ----------------------------------------------------------------------------
// timed_waypoint_path_interpolator_top
// Waypoint path store with timed arrival stamps and linear interpolation.
// ----------------------------------------------------------------------------
//  channel | ports                               | direction
//  req     | req_valid, req_stall, req_payload   | in
//  rsp     | rsp_valid, rsp_stall, rsp_payload   | out
//  csr     | csr_write_enable, csr_write_data    | in (move speed)
//
//  One request at a time. Begin and stop finish on acceptance; append squares
//  the axis differences, then takes the serial root and divides by the speed;
//  query walks segments and divides the fraction unless the end is reached.
//  Synchronous reset; the waypoint store needs no clearing pass.
//  A stalled result waits in its register; a new request is taken meanwhile.
// ----------------------------------------------------------------------------
module timed_waypoint_path_interpolator_top #(
   parameter int MAX_POINTS = twpi_pkg::MAX_POINTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  twpi_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output twpi_pkg::rsp_type rsp_payload,
   input  logic              csr_write_enable,
   input  logic [31:0]       csr_write_data
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_AP_WT  = 4'd1;
   localparam logic [3:0] S_AP_SQ  = 4'd2;
   localparam logic [3:0] S_AP_RT  = 4'd3;
   localparam logic [3:0] S_AP_DS  = 4'd4;
   localparam logic [3:0] S_AP_DV  = 4'd5;
   localparam logic [3:0] S_AP_WR  = 4'd6;
   localparam logic [3:0] S_Q_WW   = 4'd7;
   localparam logic [3:0] S_Q_WALK = 4'd8;
   localparam logic [3:0] S_Q_AW   = 4'd9;
   localparam logic [3:0] S_Q_A    = 4'd10;
   localparam logic [3:0] S_Q_DV   = 4'd11;
   localparam logic [3:0] S_Q_LERP = 4'd12;
   localparam logic [3:0] S_Q_OUT  = 4'd13;

   logic [3:0]        state_ff;
   twpi_pkg::req_type req_ff;
   logic [CW-1:0]     count_ff;
   logic [AW-1:0]     seg_ff;
   logic [31:0]       speed_ff;
   logic [AW-1:0]     addr_ff;
   logic [AW-1:0]     idx_ff;
   logic [AW-1:0]     last_ff;
   logic [1:0]        cnt_ff;
   logic [65:0]       acc_ff;
   logic [65:0]       prod_ff;
   logic [42:0]       scaled_ff;
   twpi_pkg::way_type a_ff;
   twpi_pkg::way_type b_ff;
   logic              full_ff;
   logic              nopath_ff;
   logic [31:0]       t_ff;
   logic [64:0]       lmul_ff;
   logic              lneg_ff;
   logic [31:0]       la_ff;
   logic [31:0]       lb_ff;
   logic [31:0]       pos_ff [3];
   twpi_pkg::rsp_type rsp_ff;
   logic              rsp_valid_ff;

   logic                  accept;
   logic                  out_free;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   twpi_pkg::way_type     wr_data;
   twpi_pkg::way_type     rd_data;
   twpi_pkg::way_type     req_way;
   twpi_pkg::div_req_type div_req;
   twpi_pkg::div_rsp_type div_rsp;
   logic                  sqrt_start;
   logic                  sqrt_done;
   logic [32:0]           root;
   logic [31:0]           sq_new;
   logic [31:0]           sq_old;
   logic [31:0]           l_end;
   logic [31:0]           l_beg;
   logic [32:0]           sq_dif;
   logic [32:0]           sq_mag;
   logic [32:0]           l_dif;
   logic [32:0]           l_mag;
   logic [64:0]           l_round;
   logic [39:0]           q_num;
   logic [39:0]           q_den;
   logic                  q_full;
   logic [43:0]           arr_sum;
   logic [39:0]           arr;
   logic [AW-1:0]         q_last;
   logic [AW-1:0]         q_start;
   logic [31:0]           speed_eff;

   assign accept   = req_valid && !req_stall;
   assign req_stall = state_ff != S_IDLE;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign req_way = '{x: req_ff.point_x, y: req_ff.point_y, z: req_ff.point_z,
                      arrival: req_ff.time_ms};

   // absolute axis difference for the append distance
   assign sq_new = twpi_pkg::axis_of(req_way, cnt_ff);
   assign sq_old = twpi_pkg::axis_of(rd_data, cnt_ff);
   assign sq_dif = {sq_new[31], sq_new} - {sq_old[31], sq_old};
   assign sq_mag = sq_dif[32] ? 33'(-sq_dif) : sq_dif;

   // interpolation difference b - a
   assign l_end = twpi_pkg::axis_of(b_ff, cnt_ff);
   assign l_beg = twpi_pkg::axis_of(a_ff, cnt_ff);
   assign l_dif = {l_end[31], l_end} - {l_beg[31], l_beg};
   assign l_mag = l_dif[32] ? 33'(-l_dif) : l_dif;
   assign l_round = lmul_ff + 65'h0_8000_0000;

   assign q_num  = (req_ff.time_ms > rd_data.arrival) ? req_ff.time_ms - rd_data.arrival : '0;
   assign q_den  = (b_ff.arrival > rd_data.arrival) ? b_ff.arrival - rd_data.arrival : '0;
   assign q_full = (q_den == '0) || (q_num >= q_den);

   assign arr_sum = {4'd0, rd_data.arrival} + {1'b0, scaled_ff};
   assign arr = (arr_sum > {4'd0, twpi_pkg::TIME_MAX}) ? twpi_pkg::TIME_MAX : arr_sum[39:0];

   assign q_last  = AW'(count_ff - 1'b1);
   assign q_start = (seg_ff == '0) ? AW'(1) : ((seg_ff > q_last) ? q_last : seg_ff);
   assign speed_eff = (speed_ff == '0) ? 32'd1 : speed_ff;

   assign sqrt_start = (state_ff == S_AP_SQ) && (cnt_ff == 2'd3);

   always_comb begin
      div_req = '0;
      if (state_ff == S_AP_DS) begin
         div_req.start    = 1'b1;
         div_req.dividend = scaled_ff;
         div_req.divisor  = {8'd0, speed_eff};
         div_req.steps    = 6'd43;
      end else if ((state_ff == S_Q_A) && !q_full) begin
         div_req.start   = 1'b1;
         div_req.r0      = q_num;
         div_req.divisor = q_den;
         div_req.steps   = 6'd32;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '{x: req_payload.point_x, y: req_payload.point_y,
                  z: req_payload.point_z, arrival: req_payload.time_ms};
      if (accept && (req_payload.command == twpi_pkg::CMD_BEGIN)) begin
         wr_en = 1'b1;
      end else if (state_ff == S_AP_WR) begin
         wr_en   = 1'b1;
         wr_addr = AW'(count_ff);
         wr_data = '{x: req_ff.point_x, y: req_ff.point_y, z: req_ff.point_z, arrival: arr};
      end
   end

   twpi_way_mem #(.MAX_POINTS(MAX_POINTS)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   twpi_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (acc_ff + prod_ff),
      .done     (sqrt_done),
      .root     (root)
   );

   twpi_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         seg_ff       <= AW'(1);
         speed_ff     <= twpi_pkg::MOVE_SPEED_RESET;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         addr_ff      <= '0;
      end else begin
         if (csr_write_enable) begin
            speed_ff <= csr_write_data;
         end
         if (rsp_valid_ff && !rsp_stall && !((state_ff == S_Q_OUT) && out_free)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  req_ff    <= req_payload;
                  nopath_ff <= 1'b0;
                  cnt_ff    <= '0;
                  case (req_payload.command)
                     twpi_pkg::CMD_BEGIN: begin
                        count_ff <= CW'(1);
                        seg_ff   <= AW'(1);
                     end
                     twpi_pkg::CMD_APPEND: begin
                        if ((count_ff != '0) && (count_ff < CW'(MAX_POINTS))) begin
                           addr_ff  <= q_last;
                           acc_ff   <= '0;
                           state_ff <= S_AP_WT;
                        end
                     end
                     twpi_pkg::CMD_QUERY: begin
                        if (count_ff < CW'(2)) begin
                           nopath_ff <= 1'b1;
                           state_ff  <= S_Q_OUT;
                        end else begin
                           last_ff  <= q_last;
                           idx_ff   <= q_start;
                           addr_ff  <= q_start;
                           state_ff <= S_Q_WW;
                        end
                     end
                     default: begin
                        count_ff <= '0;
                        seg_ff   <= AW'(1);
                     end
                  endcase
               end
            end
            S_AP_WT: state_ff <= S_AP_SQ;
            S_AP_SQ: begin
               prod_ff <= {33'd0, sq_mag} * {33'd0, sq_mag};
               if (cnt_ff != 2'd0) begin
                  acc_ff <= acc_ff + prod_ff;
               end
               cnt_ff <= cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  state_ff <= S_AP_RT;
               end
            end
            S_AP_RT: begin
               if (sqrt_done) begin
                  scaled_ff <= 43'(root * 10'd1000);
                  state_ff  <= S_AP_DS;
               end
            end
            S_AP_DS: state_ff <= S_AP_DV;
            S_AP_DV: begin
               if (div_rsp.done) begin
                  scaled_ff <= div_rsp.quotient;
                  state_ff  <= S_AP_WR;
               end
            end
            S_AP_WR: begin
               count_ff <= count_ff + 1'b1;
               state_ff <= S_IDLE;
            end
            S_Q_WW: state_ff <= S_Q_WALK;
            S_Q_WALK: begin
               if ((req_ff.time_ms > rd_data.arrival) && (idx_ff < last_ff)) begin
                  idx_ff   <= idx_ff + 1'b1;
                  addr_ff  <= idx_ff + 1'b1;
                  state_ff <= S_Q_WW;
               end else begin
                  b_ff     <= rd_data;
                  seg_ff   <= idx_ff;
                  addr_ff  <= idx_ff - 1'b1;
                  state_ff <= S_Q_AW;
               end
            end
            S_Q_AW: state_ff <= S_Q_A;
            S_Q_A: begin
               a_ff    <= rd_data;
               full_ff <= q_full;
               t_ff    <= '0;
               cnt_ff  <= '0;
               state_ff <= q_full ? S_Q_LERP : S_Q_DV;
            end
            S_Q_DV: begin
               if (div_rsp.done) begin
                  t_ff     <= div_rsp.quotient[31:0];
                  state_ff <= S_Q_LERP;
               end
            end
            S_Q_LERP: begin
               lmul_ff <= {32'd0, l_mag} * {33'd0, t_ff};
               lneg_ff <= l_dif[32];
               la_ff   <= l_beg;
               lb_ff   <= l_end;
               if (cnt_ff != 2'd0) begin
                  pos_ff[cnt_ff - 2'd1] <= full_ff ? lb_ff :
                     (lneg_ff ? la_ff - l_round[63:32] : la_ff + l_round[63:32]);
               end
               cnt_ff <= cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  state_ff <= S_Q_OUT;
               end
            end
            S_Q_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  if (nopath_ff) begin
                     rsp_ff <= '{pos_x: '0, pos_y: '0, pos_z: '0, segment: 6'd1,
                                 status: twpi_pkg::STATUS_NO_PATH};
                  end else begin
                     rsp_ff <= '{pos_x: pos_ff[0], pos_y: pos_ff[1], pos_z: pos_ff[2],
                                 segment: 6'(idx_ff),
                                 status: (full_ff && (idx_ff == last_ff)) ?
                                         twpi_pkg::STATUS_ARRIVED : twpi_pkg::STATUS_MOVING};
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_Q_OUT))
      else $error("result raised outside output state");
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS))
      else $error("point count beyond capacity");
   a_seg_nonzero: assert property (@(posedge clock) disable iff (reset)
      seg_ff != '0)
      else $error("segment index zero");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.status != 2'd3))
      else $error("undefined status code");
`endif

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the timed waypoint path interpolator. Loads polylines, samples
// them with timed queries and compares untyped results with a predictor of the
// arrival stamping, segment walk and interpolation. Directed rows come first,
// then random paths over several speed settings and idling patterns.
// ----------------------------------------------------------------------------
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPTS = twpi_pkg::MAX_POINTS_DEFAULT;
   localparam int SETTLE = 200;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      twpi_pkg::req_type r;
      bit                typed;
      twpi_pkg::rsp_type e;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   twpi_pkg::req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   twpi_pkg::rsp_type rsp_payload;
   logic    csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = '0;

   // predictor state
   logic [31:0] path_x[NPTS];
   logic [31:0] path_y[NPTS];
   logic [31:0] path_z[NPTS];
   logic [39:0] path_arr[NPTS];
   int unsigned path_count;
   int unsigned walk_seg;
   logic [31:0] speed_now;

   twpi_pkg::rsp_type pos_due_q[$];
   dir_row_type       dir_rows[$];
   int       send_idle;
   int       recv_idle;
   int       mismatches;
   int       cycles;
   int       sent;

   timed_waypoint_path_interpolator_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic logic [65:0] diff_square(logic [31:0] a, logic [31:0] b);
      logic [32:0] d;
      logic [32:0] m;
      d = {a[31], a} - {b[31], b};
      m = d[32] ? -d : d;
      return {33'b0, m} * {33'b0, m};
   endfunction

   function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b,
                                         logic [31:0] t, bit full);
      logic [32:0] d;
      logic [32:0] m;
      logic [65:0] p;
      if (full) return b;
      d = {b[31], b} - {a[31], a};
      m = d[32] ? -d : d;
      p = {33'b0, m} * {34'b0, t} + 66'h8000_0000;
      p = p >> 32;
      return d[32] ? a - p[31:0] : a + p[31:0];
   endfunction

   function automatic bit path_step(twpi_pkg::req_type r, output twpi_pkg::rsp_type o);
      int unsigned n;
      int unsigned last;
      int unsigned i;
      logic [65:0] s;
      logic [33:0] root;
      logic [33:0] c;
      logic [67:0] sq;
      logic [63:0] ms;
      logic [63:0] a64;
      logic [31:0] sp;
      logic [39:0] st;
      logic [39:0] en;
      logic [39:0] num;
      logic [39:0] den;
      logic [71:0] q;
      logic [31:0] t;
      bit          full;
      o = '0;
      case (r.command)
         twpi_pkg::CMD_BEGIN: begin
            path_x[0] = r.point_x;
            path_y[0] = r.point_y;
            path_z[0] = r.point_z;
            path_arr[0] = r.time_ms;
            path_count = 1;
            walk_seg = 1;
            return 0;
         end
         twpi_pkg::CMD_APPEND: begin
            n = path_count;
            if (n == 0 || n >= NPTS) return 0;
            s = diff_square(r.point_x, path_x[n-1]) + diff_square(r.point_y, path_y[n-1])
                + diff_square(r.point_z, path_z[n-1]);
            root = '0;
            for (int b = 33; b >= 0; b--) begin
               c = root | (34'd1 << b);
               sq = {34'b0, c} * {34'b0, c};
               if (sq <= {2'b0, s}) root = c;
            end
            sp = (speed_now == 0) ? 32'd1 : speed_now;
            ms = ({30'b0, root} * 64'd1000) / {32'b0, sp};
            a64 = {24'b0, path_arr[n-1]} + ms;
            if (a64 > {24'b0, twpi_pkg::TIME_MAX}) a64 = {24'b0, twpi_pkg::TIME_MAX};
            path_x[n] = r.point_x;
            path_y[n] = r.point_y;
            path_z[n] = r.point_z;
            path_arr[n] = a64[39:0];
            path_count = n + 1;
            return 0;
         end
         twpi_pkg::CMD_STOP: begin
            path_count = 0;
            walk_seg = 1;
            return 0;
         end
         default: begin
            if (path_count < 2) begin
               o.segment = 6'd1;
               o.status = twpi_pkg::STATUS_NO_PATH;
               return 1;
            end
            last = path_count - 1;
            i = walk_seg;
            if (i < 1) i = 1;
            if (i > last) i = last;
            while (r.time_ms > path_arr[i] && i < last) i++;
            walk_seg = i;
            st = path_arr[i-1];
            en = path_arr[i];
            num = (r.time_ms > st) ? r.time_ms - st : '0;
            den = (en > st) ? en - st : '0;
            full = (den == 0) || (num >= den);
            t = '0;
            if (!full) begin
               q = {num, 32'b0} / {32'b0, den};
               t = q[31:0];
            end
            o.pos_x = blend(path_x[i-1], path_x[i], t, full);
            o.pos_y = blend(path_y[i-1], path_y[i], t, full);
            o.pos_z = blend(path_z[i-1], path_z[i], t, full);
            o.segment = i[5:0];
            o.status = (full && i == last) ? twpi_pkg::STATUS_ARRIVED : twpi_pkg::STATUS_MOVING;
            return 1;
         end
      endcase
   endfunction

   // result checking
   always @(posedge clock) begin
      twpi_pkg::rsp_type e;
      if (!reset) begin
         rsp_stall <= (recv_idle != 0) && ($urandom_range(99) < recv_idle);
         if (rsp_valid && !rsp_stall) begin
            if (pos_due_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", rsp_payload);
            end else begin
               e = pos_due_q.pop_front();
               if (rsp_payload.pos_x !== e.pos_x || rsp_payload.pos_y !== e.pos_y ||
                   rsp_payload.pos_z !== e.pos_z || rsp_payload.segment !== e.segment ||
                   rsp_payload.status !== e.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p actual %p", e, rsp_payload);
               end
            end
         end
      end
   end

   task automatic send_req(twpi_pkg::req_type r, bit typed = 0, twpi_pkg::rsp_type te = '0);
      twpi_pkg::rsp_type o;
      while (send_idle != 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (path_step(r, o)) pos_due_q.push_back(typed ? te : o);
      sent++;
   endtask

   task automatic write_speed(logic [31:0] v);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pos_due_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      speed_now = v;
   endtask

   function automatic twpi_pkg::req_type mk(logic [1:0] c, logic [31:0] x, logic [31:0] y,
                                            logic [31:0] z, logic [39:0] t);
      twpi_pkg::req_type r;
      r.command = c;
      r.point_x = x;
      r.point_y = y;
      r.point_z = z;
      r.time_ms = t;
      return r;
   endfunction

   task automatic add_row(twpi_pkg::req_type r, bit typed = 0, logic [31:0] ex = 0,
                          logic [31:0] ey = 0, logic [31:0] ez = 0,
                          logic [5:0] sg = 1, logic [1:0] st = twpi_pkg::STATUS_NO_PATH);
      dir_row_type d;
      d.r = r;
      d.typed = typed;
      d.e.pos_x = ex;
      d.e.pos_y = ey;
      d.e.pos_z = ez;
      d.e.segment = sg;
      d.e.status = st;
      dir_rows.push_back(d);
   endtask

   function automatic logic [39:0] rand40();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [39:0] pick_time();
      logic [39:0] lo;
      logic [39:0] hi;
      logic [63:0] span;
      int          k;
      k = $urandom_range(99);
      if (path_count == 0 || k < 5) return rand40();
      lo = path_arr[0];
      hi = path_arr[path_count-1];
      span = {24'b0, hi - lo} + 1;
      if (k < 15) return (lo > 100) ? lo - $urandom_range(100) : '0;
      if (k < 25)
         return (hi < twpi_pkg::TIME_MAX - 100) ? hi + $urandom_range(100) : twpi_pkg::TIME_MAX;
      return lo + 40'({$urandom, $urandom} % span);
   endfunction

   function automatic logic [31:0] next_coord(logic [31:0] p);
      if ($urandom_range(19) == 0) return $urandom;
      return p + 32'(int'($urandom_range(2097152)) - 1048576);
   endfunction

   task automatic random_path(int appends);
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [39:0] t0;
      x = next_coord($urandom);
      y = next_coord($urandom);
      z = next_coord($urandom);
      t0 = ($urandom_range(9) == 0) ? rand40() : 40'($urandom);
      send_req(mk(twpi_pkg::CMD_BEGIN, x, y, z, t0));
      for (int a = 0; a < appends; a++) begin
         x = next_coord(x);
         y = next_coord(y);
         z = next_coord(z);
         send_req(mk(twpi_pkg::CMD_APPEND, x, y, z, rand40()));
         if ($urandom_range(3) == 0)
            send_req(mk(twpi_pkg::CMD_QUERY, $urandom, $urandom, $urandom, pick_time()));
      end
      repeat ($urandom_range(2, 10))
         send_req(mk(twpi_pkg::CMD_QUERY, $urandom, $urandom, $urandom, pick_time()));
      case ($urandom_range(9))
         0: send_req(mk(twpi_pkg::CMD_STOP, $urandom, $urandom, $urandom, rand40()));
         1: send_req(mk(2'($urandom), $urandom, $urandom, $urandom, rand40()));
         default: ;
      endcase
   endtask

   initial begin
      logic [31:0] speeds[5];
      speed_now = twpi_pkg::MOVE_SPEED_RESET;
      path_count = 0;
      walk_seg = 1;
      send_idle = 0;
      recv_idle = 0;
      mismatches = 0;
      cycles = 0;
      sent = 0;
      speeds = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd65536, 32'd0};
      speeds[4] = $urandom_range(1, 32'h0010_0000);

      add_row(mk(twpi_pkg::CMD_QUERY, 0, 0, 0, 0), 1);
      add_row(mk(twpi_pkg::CMD_APPEND, 32'h0001_0000, 0, 0, 0));
      add_row(mk(twpi_pkg::CMD_BEGIN, 0, 0, 0, 0));
      add_row(mk(twpi_pkg::CMD_QUERY, 0, 0, 0, 40'd10), 1);
      add_row(mk(twpi_pkg::CMD_APPEND, 32'h0003_0000, 32'h0004_0000, 0, 0));
      add_row(mk(twpi_pkg::CMD_QUERY, 0, 0, 0, 0), 1, 0, 0, 0, 6'd1,
              twpi_pkg::STATUS_MOVING);
      add_row(mk(twpi_pkg::CMD_QUERY, 0, 0, 0, 40'd2500), 1, 32'h0001_8000, 32'h0002_0000,
              0, 6'd1, twpi_pkg::STATUS_MOVING);
      add_row(mk(twpi_pkg::CMD_QUERY, 0, 0, 0, 40'd5000), 1, 32'h0003_0000, 32'h0004_0000,
              0, 6'd1, twpi_pkg::STATUS_ARRIVED);
      add_row(mk(twpi_pkg::CMD_APPEND, 32'h0003_0000, 32'h0004_0000, 0, 0));
      add_row(mk(twpi_pkg::CMD_QUERY, 0, 0, 0, 40'd5000));
      add_row(mk(twpi_pkg::CMD_QUERY, 0, 0, 0, 40'd6000));
      add_row(mk(twpi_pkg::CMD_STOP, 0, 0, 0, 0));
      add_row(mk(twpi_pkg::CMD_QUERY, 0, 0, 0, 40'd6000), 1);
      add_row(mk(twpi_pkg::CMD_BEGIN, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 twpi_pkg::TIME_MAX - 10));
      add_row(mk(twpi_pkg::CMD_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 twpi_pkg::TIME_MAX));
      add_row(mk(twpi_pkg::CMD_QUERY, 0, 0, 0, twpi_pkg::TIME_MAX - 5));
      add_row(mk(twpi_pkg::CMD_QUERY, 0, 0, 0, twpi_pkg::TIME_MAX), 1, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 6'd1, twpi_pkg::STATUS_ARRIVED);
      add_row(mk(twpi_pkg::CMD_BEGIN, 32'hFFF0_0000, 32'h0010_0000, 32'hFFFF_FFFF, 40'd1000));
      add_row(mk(twpi_pkg::CMD_APPEND, 32'h0010_0000, 32'hFFF0_0000, 32'h0000_0001, 0));
      add_row(mk(twpi_pkg::CMD_QUERY, 0, 0, 0, 40'd500), 1, 32'hFFF0_0000, 32'h0010_0000,
              32'hFFFF_FFFF, 6'd1, twpi_pkg::STATUS_MOVING);
      add_row(mk(twpi_pkg::CMD_QUERY, 0, 0, 0, 40'd1100));
      add_row(mk(twpi_pkg::CMD_BEGIN, 32'h0001_0000, 0, 0, 40'd7));
      add_row(mk(twpi_pkg::CMD_QUERY, 0, 0, 0, 40'd7), 1);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[k]) send_req(dir_rows[k].r, dir_rows[k].typed, dir_rows[k].e);

      for (int p = 0; p < 5; p++) begin
         write_speed(speeds[p]);
         send_idle = (p < 2) ? 30 : (p < 4) ? 74 : 0;
         recv_idle = (p < 2) ? 74 : (p < 4) ? 30 : 0;
         random_path(70);
         while (sent < 25 + 310 * (p + 1))
            random_path($urandom_range(4) == 0 ? $urandom_range(9, 20) : $urandom_range(1, 6));
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pos_due_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && pos_due_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: timed_waypoint_path_interpolator_top.f
design/twpi_pkg.sv
design/twpi_way_mem.sv
design/twpi_sqrt.sv
design/twpi_div.sv
design/timed_waypoint_path_interpolator_top.sv
dv/tb.sv
